// ===== hdl/rkc_pkg.sv =====
package rkc_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int COEF_FRAC_BITS = 8;
    localparam int KS             = 3;
    localparam int NCH            = 3;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WID_W   = COL_W + 1;
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int HGT_W   = ROW_W + 1;
    localparam int PIX_W   = 32;
    localparam int CH_W    = 8;
    localparam int COEF_W  = 16;
    localparam int CROW_W  = KS * COEF_W;
    localparam int PROD_W  = CH_W + 1 + COEF_W;
    localparam int PART_W  = PROD_W + 2;
    localparam int SUM_W   = PART_W + 2;

    localparam int CFG_DW  = 64;
    localparam int CFG_AW  = 6;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_COEF_TOP = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_MID = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_BOT = 3'd2;
    localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd3;
    localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd4;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic [CROW_W-1:0] COEF_TOP_RST = 48'h0;
    localparam logic [CROW_W-1:0] COEF_MID_RST = 48'h0000_0100_0000;
    localparam logic [CROW_W-1:0] COEF_BOT_RST = 48'h0;
    localparam logic [WID_W-1:0]  WIDTH_RST    = 11'd640;
    localparam logic [HGT_W-1:0]  HEIGHT_RST   = 13'd480;

    localparam logic [CH_W-1:0]   PIX_MAX      = 8'd255;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [KS-1:0] col_t;
    typedef logic [KS-1:0][KS-1:0][PIX_W-1:0] win_t;
    typedef logic [KS-1:0][CROW_W-1:0] coef_set_t;

    typedef struct packed {
        pix_t older;
        pix_t newer;
    } entry_t;

    typedef struct packed {
        logic emit;
        logic inner;
        logic fend;
    } tag_t;

    typedef struct packed {
        logic step;
        logic direct;
        tag_t tag;
    } step_t;

endpackage

// ===== hdl/rkc_ram.sv =====
module rkc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rkc_filter.sv =====
module rkc_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  rkc_pkg::step_t     ctl,
    input  rkc_pkg::col_t      col,
    input  rkc_pkg::coef_set_t coef,
    output logic               out_valid,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out,
    output logic [7:0]         alpha_out,
    output logic               frame_end
);
    import rkc_pkg::*;

    function automatic logic [CH_W-1:0] clamp_px(input logic signed [SUM_W-1:0] s);
        if (s[SUM_W-1])
        begin
            return '0;
        end
        else if (|s[SUM_W-2:COEF_FRAC_BITS+CH_W])
        begin
            return PIX_MAX;
        end
        else
        begin
            return s[COEF_FRAC_BITS+CH_W-1:COEF_FRAC_BITS];
        end
    endfunction

    win_t win_reg, win_next;
    pix_t s2_ctr_reg, s3_ctr_reg, s4_ctr_reg;
    tag_t s2_tag_reg, s3_tag_reg, s4_tag_reg;

    logic signed [PROD_W-1:0] prod_next [NCH][KS][KS];
    logic signed [PROD_W-1:0] prod_reg  [NCH][KS][KS];
    logic signed [PART_W-1:0] part_next [NCH][KS];
    logic signed [PART_W-1:0] part_reg  [NCH][KS];

    pix_t res_next;
    pix_t res_reg;
    logic out_valid_reg;
    logic frame_end_reg;

    // column shift: newest column enters on the right
    always_comb
    begin
        win_next = win_reg;
        if (ctl.step)
        begin
            for (int r = 0; r < KS; r++)
            begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
                win_next[r][2] = col[r];
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            for (int r = 0; r < KS; r++)
            begin
                for (int c = 0; c < KS; c++)
                begin
                    prod_next[ch][r][c] = $signed({1'b0, win_reg[r][c][CH_W*ch +: CH_W]})
                                        * $signed(coef[c][COEF_W*r +: COEF_W]);
                end
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            for (int r = 0; r < KS; r++)
            begin
                part_next[ch][r] = PART_W'(prod_reg[ch][r][0]) + PART_W'(prod_reg[ch][r][1])
                                 + PART_W'(prod_reg[ch][r][2]);
            end
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        res_next = s4_ctr_reg;
        for (int ch = 0; ch < NCH; ch++)
        begin
            sum = SUM_W'(part_reg[ch][0]) + SUM_W'(part_reg[ch][1])
                + SUM_W'(part_reg[ch][2]);
            if (s4_tag_reg.inner)
            begin
                res_next[CH_W*ch +: CH_W] = clamp_px(sum);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            win_reg    <= win_next;
            s2_ctr_reg <= ctl.direct ? col[1] : win_next[1][1];
            s3_ctr_reg <= s2_ctr_reg;
            s4_ctr_reg <= s3_ctr_reg;
            prod_reg   <= prod_next;
            part_reg   <= part_next;
            res_reg    <= res_next;
            frame_end_reg <= s4_tag_reg.fend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_tag_reg    <= '0;
            s3_tag_reg    <= '0;
            s4_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_tag_reg    <= ctl.tag;
            s3_tag_reg    <= s2_tag_reg;
            s4_tag_reg    <= s3_tag_reg;
            out_valid_reg <= s4_tag_reg.emit;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = res_reg[7:0];
    assign green_out = res_reg[15:8];
    assign blue_out  = res_reg[23:16];
    assign alpha_out = res_reg[31:24];
    assign frame_end = frame_end_reg;

endmodule

// ===== hdl/rgba_kernel_convolution.sv =====
// A request passes stage 1, then the window, product, partial-sum and result registers.
// Throughput: one request per cycle, pixel or flush; output stall holds every stage.
// Results trail the pixel stream by one row plus one pixel; flush requests drain the rest.
// Line memory: one 64-bit entry per column, one read and one write per cycle.
// Reset (rst_n, async, active low) restores configuration, counters and control flags;
// data registers and the line memory are not cleared; the memory needs no clearing pass.
module rgba_kernel_convolution (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rkc_pkg::CFG_AW-1:0] paddr,
    input  logic [rkc_pkg::CFG_DW-1:0] pwdata,
    output logic [rkc_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       kind,
    input  logic [7:0]                 red_in,
    input  logic [7:0]                 green_in,
    input  logic [7:0]                 blue_in,
    input  logic [7:0]                 alpha_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 red_out,
    output logic [7:0]                 green_out,
    output logic [7:0]                 blue_out,
    output logic [7:0]                 alpha_out,
    output logic                       frame_end
);
    import rkc_pkg::*;

    logic [CROW_W-1:0] coef_top_reg, coef_mid_reg, coef_bot_reg;
    logic [WID_W-1:0]  width_raw_reg, w_reg, w_clamp;
    logic [HGT_W-1:0]  height_raw_reg, h_reg, h_clamp;

    logic [COL_W-1:0]  jx_reg, jx_next, ex_reg, ex_next;
    logic [HGT_W-1:0]  jy_reg, jy_next;
    logic [ROW_W-1:0]  ey_reg, ey_next;
    logic              done_reg, done_next;

    logic              adv, accept, cfg_wr, geom_wr;
    logic [IDX_W-1:0]  cfg_idx;
    logic              do_pix, do_flush, flush_direct, do_step, do_emit, do_read;
    logic              primed, inner, fend, last_pix, fwd;
    logic [COL_W-1:0]  rd_addr;

    step_t             s1_ctl_reg;
    logic [COL_W-1:0]  s1_addr_reg;
    pix_t              s1_pix_reg;
    logic              s1_fwd_reg;
    entry_t            lw_data_reg;
    entry_t            ram_q, q_eff, wr_data;
    logic              ram_we;
    col_t              col;
    coef_set_t         coef;

    assign pready   = 1'b1;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[CFG_AW-1:3];
    assign geom_wr  = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

    // configuration
    always_comb
    begin
        if (pwdata[WID_W-1:0] == '0)
        begin
            w_clamp = WID_W'(1);
        end
        else if (pwdata[WID_W-1:0] > WID_W'(MAX_WIDTH))
        begin
            w_clamp = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = pwdata[WID_W-1:0];
        end
        if (pwdata[HGT_W-1:0] == '0)
        begin
            h_clamp = HGT_W'(1);
        end
        else if (pwdata[HGT_W-1:0] > HGT_W'(MAX_HEIGHT))
        begin
            h_clamp = HGT_W'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = pwdata[HGT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg   <= COEF_TOP_RST;
            coef_mid_reg   <= COEF_MID_RST;
            coef_bot_reg   <= COEF_BOT_RST;
            width_raw_reg  <= WIDTH_RST;
            height_raw_reg <= HEIGHT_RST;
            w_reg          <= WIDTH_RST;
            h_reg          <= HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_COEF_TOP: coef_top_reg <= pwdata[CROW_W-1:0];
                REG_COEF_MID: coef_mid_reg <= pwdata[CROW_W-1:0];
                REG_COEF_BOT: coef_bot_reg <= pwdata[CROW_W-1:0];
                REG_WIDTH:
                begin
                    width_raw_reg <= pwdata[WID_W-1:0];
                    w_reg         <= w_clamp;
                end
                REG_HEIGHT:
                begin
                    height_raw_reg <= pwdata[HGT_W-1:0];
                    h_reg          <= h_clamp;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_COEF_TOP: prdata = CFG_DW'(coef_top_reg);
            REG_COEF_MID: prdata = CFG_DW'(coef_mid_reg);
            REG_COEF_BOT: prdata = CFG_DW'(coef_bot_reg);
            REG_WIDTH:    prdata = CFG_DW'(width_raw_reg);
            REG_HEIGHT:   prdata = CFG_DW'(height_raw_reg);
            default:      prdata = '0;
        endcase
    end

    // request decode; jx/jy track the next column to be fed in, ex/ey the next result
    assign do_pix       = accept && (kind == KIND_PIXEL) && !done_reg;
    assign do_flush     = accept && (kind == KIND_FLUSH) && done_reg;
    assign flush_direct = do_flush && (h_reg == HGT_W'(1));
    assign do_step      = do_pix || (do_flush && !flush_direct);
    assign do_read      = do_step || flush_direct;
    assign primed       = (jy_reg >= HGT_W'(2)) || (jy_reg == HGT_W'(1) && jx_reg != '0);
    assign do_emit      = do_flush || (do_pix && primed);
    assign inner        = (ex_reg != '0) && (({1'b0, ex_reg} + WID_W'(1)) < w_reg)
                       && (ey_reg != '0) && (({1'b0, ey_reg} + HGT_W'(1)) < h_reg);
    assign fend         = ({1'b0, ex_reg} == w_reg - WID_W'(1))
                       && ({1'b0, ey_reg} == h_reg - HGT_W'(1));
    assign last_pix     = ({1'b0, jx_reg} == w_reg - WID_W'(1))
                       && (jy_reg == h_reg - HGT_W'(1));
    assign rd_addr      = flush_direct ? ex_reg : jx_reg;
    // same entry written by the step leaving stage 1 at this edge
    assign fwd          = do_read && s1_ctl_reg.step && (s1_addr_reg == rd_addr);

    always_comb
    begin
        jx_next   = jx_reg;
        jy_next   = jy_reg;
        ex_next   = ex_reg;
        ey_next   = ey_reg;
        done_next = done_reg;
        if (geom_wr || (do_emit && fend))
        begin
            jx_next   = '0;
            jy_next   = '0;
            ex_next   = '0;
            ey_next   = '0;
            done_next = 1'b0;
        end
        else
        begin
            if (do_step)
            begin
                if ({1'b0, jx_reg} == w_reg - WID_W'(1))
                begin
                    jx_next = '0;
                    jy_next = jy_reg + HGT_W'(1);
                end
                else
                begin
                    jx_next = jx_reg + COL_W'(1);
                end
            end
            if (do_pix && last_pix)
            begin
                done_next = 1'b1;
            end
            if (do_emit)
            begin
                if ({1'b0, ex_reg} == w_reg - WID_W'(1))
                begin
                    ex_next = '0;
                    ey_next = ey_reg + ROW_W'(1);
                end
                else
                begin
                    ex_next = ex_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jx_reg     <= '0;
            jy_reg     <= '0;
            ex_reg     <= '0;
            ey_reg     <= '0;
            done_reg   <= 1'b0;
            s1_ctl_reg <= '0;
            s1_fwd_reg <= 1'b0;
        end
        else
        begin
            jx_reg   <= jx_next;
            jy_reg   <= jy_next;
            ex_reg   <= ex_next;
            ey_reg   <= ey_next;
            done_reg <= done_next;
            if (adv)
            begin
                s1_ctl_reg.step   <= do_step;
                s1_ctl_reg.direct <= flush_direct;
                s1_ctl_reg.tag    <= '{emit: do_emit, inner: inner, fend: fend};
                s1_fwd_reg        <= fwd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_addr_reg <= rd_addr;
            s1_pix_reg  <= {alpha_in, blue_in, green_in, red_in};
        end
        if (ram_we)
        begin
            lw_data_reg <= wr_data;
        end
    end

    // line memory: entry per column holds the two previous rows
    assign q_eff   = s1_fwd_reg ? lw_data_reg : ram_q;
    assign ram_we  = adv && s1_ctl_reg.step;
    assign wr_data = '{older: q_eff.newer, newer: s1_pix_reg};

    rkc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (wr_data),
        .re    (do_read),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    assign col[0] = q_eff.older;
    assign col[1] = q_eff.newer;
    assign col[2] = s1_pix_reg;
    assign coef   = {coef_bot_reg, coef_mid_reg, coef_top_reg};

    rkc_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl       (s1_ctl_reg),
        .col       (col),
        .coef      (coef),
        .out_valid (out_valid),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out),
        .frame_end (frame_end)
    );

    ap_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, jx_reg} < w_reg))
        else $error("input column beyond frame width");

    ap_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (({1'b0, ex_reg} < w_reg) && ({1'b0, ey_reg} < h_reg)))
        else $error("result position outside frame");

    ap_done_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg == (jy_reg >= h_reg)))
        else $error("frame-complete flag disagrees with row count");

    ap_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (do_emit && fend) |=> (ex_reg == '0 && ey_reg == '0 && jx_reg == '0 && !done_reg))
        else $error("counters not restarted after last result of frame");

endmodule
